// ===== hw/rtl/thc_pkg.sv =====
`timescale 1ns / 1ps

package thc_pkg;

    // time-of-day limits
    localparam logic [3:0] HOUR_TOP   = 4'd12;
    localparam logic [3:0] HOUR_FIRST = 4'd1;
    localparam logic [5:0] MINSEC_TOP = 6'd59;
    localparam logic [5:0] DEC_BASE   = 6'd10;

    // touch limit reset values
    localparam int LEFT_LIMIT_RESET  = 106;
    localparam int RIGHT_LIMIT_RESET = 213;
    localparam int ROW_LIMIT_RESET   = 120;

    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LEFT_LIMIT  = 2'd0,
        CFG_RIGHT_LIMIT = 2'd1,
        CFG_ROW_LIMIT   = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        REGION_NONE     = 3'd0,
        REGION_HOUR_INC = 3'd1,
        REGION_MIN_INC  = 3'd2,
        REGION_SEC_INC  = 3'd3,
        REGION_HOUR_DEC = 3'd4,
        REGION_MIN_DEC  = 3'd5,
        REGION_SEC_DEC  = 3'd6
    } region_t;

    typedef struct packed {
        logic [3:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } time_t;

    typedef struct packed {
        logic       hour_tens;
        logic [3:0] hour_ones;
        logic [2:0] minute_tens;
        logic [3:0] minute_ones;
        logic [2:0] second_tens;
        logic [3:0] second_ones;
        logic       hours_changed;
        logic       minutes_changed;
        logic       seconds_changed;
        logic       redraw_all;
        region_t    touch_region;
    } result_t;

endpackage

// ===== hw/rtl/thc_intf.sv =====
`timescale 1ns / 1ps

interface thc_item_if #(
    parameter int COORD_WIDTH = 10
);
    logic                   valid;
    logic                   ready;
    logic                   func;
    logic [COORD_WIDTH-1:0] touch_x;
    logic [COORD_WIDTH-1:0] touch_y;

    modport source (output valid, output func, output touch_x, output touch_y, input ready);
    modport sink   (input valid, input func, input touch_x, input touch_y, output ready);
endinterface

interface thc_result_if;
    logic       valid;
    logic       ready;
    logic       hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [2:0] second_tens;
    logic [3:0] second_ones;
    logic       hours_changed;
    logic       minutes_changed;
    logic       seconds_changed;
    logic       redraw_all;
    logic [2:0] touch_region;

    modport source (
        output valid, output hour_tens, output hour_ones, output minute_tens,
        output minute_ones, output second_tens, output second_ones,
        output hours_changed, output minutes_changed, output seconds_changed,
        output redraw_all, output touch_region, input ready
    );
    modport sink (
        input valid, input hour_tens, input hour_ones, input minute_tens,
        input minute_ones, input second_tens, input second_ones,
        input hours_changed, input minutes_changed, input seconds_changed,
        input redraw_all, input touch_region, output ready
    );
endinterface

interface thc_cfg_if #(
    parameter int COORD_WIDTH = 10,
    parameter int INDEX_W     = 2
);
    logic                   valid;
    logic                   ready;
    logic [INDEX_W-1:0]     index;
    logic [COORD_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/thc_step.sv =====
`timescale 1ns / 1ps

module thc_step #(
    parameter int COORD_WIDTH = 10
) (
    input  thc_pkg::time_t          cur,
    input  logic                    func,
    input  logic [COORD_WIDTH-1:0]  touch_x,
    input  logic [COORD_WIDTH-1:0]  touch_y,
    input  logic [COORD_WIDTH-1:0]  left_limit,
    input  logic [COORD_WIDTH-1:0]  right_limit,
    input  logic [COORD_WIDTH-1:0]  row_limit,
    output thc_pkg::time_t          nxt,
    output thc_pkg::result_t        res
);
    import thc_pkg::*;

    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if      (v >= 6'd50) t = 3'd5;
        else if (v >= 6'd40) t = 3'd4;
        else if (v >= 6'd30) t = 3'd3;
        else if (v >= 6'd20) t = 3'd2;
        else if (v >= 6'd10) t = 3'd1;
        else                 t = 3'd0;
        return t;
    endfunction

    logic       sec_wrap, min_wrap;
    logic [5:0] sec_up, sec_down, min_up, min_down;
    logic [3:0] hour_up, hour_down;
    logic       x_lt_l, x_gt_l, x_lt_r, x_gt_r, y_lt_m, y_gt_m;
    region_t    region;
    logic       hc, mc, sc, redraw;
    logic [2:0] min_tens, sec_tens;
    logic       hour_ge10;

    assign sec_wrap  = cur.second >= MINSEC_TOP;
    assign min_wrap  = cur.minute >= MINSEC_TOP;
    assign sec_up    = sec_wrap ? 6'd0 : cur.second + 6'd1;
    assign min_up    = min_wrap ? 6'd0 : cur.minute + 6'd1;
    assign sec_down  = (cur.second == 6'd0) ? MINSEC_TOP : cur.second - 6'd1;
    assign min_down  = (cur.minute == 6'd0) ? MINSEC_TOP : cur.minute - 6'd1;
    assign hour_up   = (cur.hour >= HOUR_TOP) ? HOUR_FIRST : cur.hour + 4'd1;
    assign hour_down = (cur.hour <= HOUR_FIRST) ? HOUR_TOP : cur.hour - 4'd1;

    assign x_lt_l = touch_x < left_limit;
    assign x_gt_l = touch_x > left_limit;
    assign x_lt_r = touch_x < right_limit;
    assign x_gt_r = touch_x > right_limit;
    assign y_lt_m = touch_y < row_limit;
    assign y_gt_m = touch_y > row_limit;

    // first matching key wins
    always_comb
    begin
        priority if (x_lt_l && y_lt_m)           region = REGION_HOUR_INC;
        else if (y_lt_m && x_gt_l && x_lt_r)     region = REGION_MIN_INC;
        else if (y_lt_m && x_gt_r)               region = REGION_SEC_INC;
        else if (y_gt_m && x_lt_l)               region = REGION_HOUR_DEC;
        else if (y_gt_m && x_gt_l && x_lt_r)     region = REGION_MIN_DEC;
        else if (y_gt_m && x_gt_r)               region = REGION_SEC_DEC;
        else                                     region = REGION_NONE;
    end

    always_comb
    begin
        nxt    = cur;
        hc     = 1'b0;
        mc     = 1'b0;
        sc     = 1'b0;
        redraw = 1'b0;
        if (!func)
        begin
            // tick with carry
            nxt.second = sec_up;
            sc         = 1'b1;
            if (sec_wrap)
            begin
                nxt.minute = min_up;
                mc         = 1'b1;
                if (min_wrap)
                begin
                    nxt.hour = hour_up;
                    hc       = 1'b1;
                    redraw   = 1'b1;
                end
            end
        end
        else
        begin
            unique case (region)
                REGION_HOUR_INC: begin nxt.hour   = hour_up;   hc = 1'b1; end
                REGION_MIN_INC:  begin nxt.minute = min_up;    mc = 1'b1; end
                REGION_SEC_INC:  begin nxt.second = sec_up;    sc = 1'b1; end
                REGION_HOUR_DEC: begin nxt.hour   = hour_down; hc = 1'b1; end
                REGION_MIN_DEC:  begin nxt.minute = min_down;  mc = 1'b1; end
                REGION_SEC_DEC:  begin nxt.second = sec_down;  sc = 1'b1; end
                default:         begin end
            endcase
        end
    end

    assign min_tens  = tens_of(nxt.minute);
    assign sec_tens  = tens_of(nxt.second);
    assign hour_ge10 = nxt.hour >= 4'd10;

    always_comb
    begin
        res.hour_tens       = hour_ge10;
        res.hour_ones       = hour_ge10 ? nxt.hour - 4'd10 : nxt.hour;
        res.minute_tens     = min_tens;
        res.minute_ones     = 4'(nxt.minute - 6'(min_tens) * DEC_BASE);
        res.second_tens     = sec_tens;
        res.second_ones     = 4'(nxt.second - 6'(sec_tens) * DEC_BASE);
        res.hours_changed   = hc;
        res.minutes_changed = mc;
        res.seconds_changed = sc;
        res.redraw_all      = redraw;
        res.touch_region    = func ? region : REGION_NONE;
    end

endmodule

// ===== hw/rtl/twelve_hour_clock_with_set_keys.sv =====
`timescale 1ns / 1ps

// channel | dir  | beat contents
// --------+------+-----------------------------------------------------------
// item    | in   | func (tick / touch), touch_x, touch_y
// result  | out  | bcd hours/minutes/seconds, changed flags, redraw_all, region
// cfg     | in   | index (0 left, 1 right, 2 row limit), data
//
// one item per cycle while the result side is ready; its result beat shows the cycle
// after acceptance, set by the single result register after the time update logic
// rst_n (async, active low) gives 1:00:00 and the default touch limits
// a stalled result holds in its register; a new item is taken in the same
// cycle the held result leaves, cfg is always ready

module twelve_hour_clock_with_set_keys #(
    parameter int COORD_WIDTH = 10
) (
    input  logic         clk,
    input  logic         rst_n,
    thc_item_if.sink     item,
    thc_result_if.source result,
    thc_cfg_if.sink      cfg
);
    import thc_pkg::*;

    // time of day
    time_t   time_reg;
    time_t   time_next;

    // touch limits
    logic [COORD_WIDTH-1:0] left_limit_reg;
    logic [COORD_WIDTH-1:0] right_limit_reg;
    logic [COORD_WIDTH-1:0] row_limit_reg;

    // output register
    result_t result_reg;
    result_t result_next;
    logic    out_valid_reg;

    logic    accept;

    // input taken whenever the output register is free or draining
    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    thc_step #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_step (
        .cur         (time_reg),
        .func        (item.func),
        .touch_x     (item.touch_x),
        .touch_y     (item.touch_y),
        .left_limit  (left_limit_reg),
        .right_limit (right_limit_reg),
        .row_limit   (row_limit_reg),
        .nxt         (time_next),
        .res         (result_next)
    );

    // time state advances on every accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg.hour   <= HOUR_FIRST;
            time_reg.minute <= 6'd0;
            time_reg.second <= 6'd0;
        end
        else if (accept)
        begin
            time_reg <= time_next;
        end
    end

    // limit registers, writes to unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_limit_reg  <= COORD_WIDTH'(LEFT_LIMIT_RESET);
            right_limit_reg <= COORD_WIDTH'(RIGHT_LIMIT_RESET);
            row_limit_reg   <= COORD_WIDTH'(ROW_LIMIT_RESET);
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_LEFT_LIMIT:  left_limit_reg  <= cfg.data;
                CFG_RIGHT_LIMIT: right_limit_reg <= cfg.data;
                CFG_ROW_LIMIT:   row_limit_reg   <= cfg.data;
                default:         begin end
            endcase
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.hour_tens       = result_reg.hour_tens;
    assign result.hour_ones       = result_reg.hour_ones;
    assign result.minute_tens     = result_reg.minute_tens;
    assign result.minute_ones     = result_reg.minute_ones;
    assign result.second_tens     = result_reg.second_tens;
    assign result.second_ones     = result_reg.second_ones;
    assign result.hours_changed   = result_reg.hours_changed;
    assign result.minutes_changed = result_reg.minutes_changed;
    assign result.seconds_changed = result_reg.seconds_changed;
    assign result.redraw_all      = result_reg.redraw_all;
    assign result.touch_region    = result_reg.touch_region;

endmodule

// ===== tb/clock_tb_pkg.sv =====
`timescale 1ns / 1ps

package clock_tb_pkg;
    import thc_pkg::*;

    class clock_scoreboard;
        logic [3:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [9:0] left_lim;
        logic [9:0] right_lim;
        logic [9:0] row_lim;
        result_t    expected_q[$];
        int         errors;

        function new();
            hour      = HOUR_FIRST;
            minute    = '0;
            second    = '0;
            left_lim  = 10'(LEFT_LIMIT_RESET);
            right_lim = 10'(RIGHT_LIMIT_RESET);
            row_lim   = 10'(ROW_LIMIT_RESET);
            errors    = 0;
        endfunction

        function void set_limit(cfg_index_t idx, logic [9:0] val);
            case (idx)
                CFG_LEFT_LIMIT:  left_lim = val;
                CFG_RIGHT_LIMIT: right_lim = val;
                CFG_ROW_LIMIT:   row_lim = val;
                default: ;
            endcase
        endfunction

        // first matching key wins, also when the left limit is above the right one
        function region_t key_at(logic [9:0] x, logic [9:0] y);
            if (x < left_lim && y < row_lim) return REGION_HOUR_INC;
            if (y < row_lim && x > left_lim && x < right_lim) return REGION_MIN_INC;
            if (y < row_lim && x > right_lim) return REGION_SEC_INC;
            if (y > row_lim && x < left_lim) return REGION_HOUR_DEC;
            if (y > row_lim && x > left_lim && x < right_lim) return REGION_MIN_DEC;
            if (y > row_lim && x > right_lim) return REGION_SEC_DEC;
            return REGION_NONE;
        endfunction

        // advance the time for one accepted item and queue the beat it should give
        function void note_item(logic func, logic [9:0] x, logic [9:0] y);
            result_t want;
            bit      sec_wrap;
            bit      min_wrap;
            int      h;
            int      m;
            int      s;
            want     = '0;
            sec_wrap = 1'b0;
            min_wrap = 1'b0;
            if (!func) begin
                sec_wrap = (second >= MINSEC_TOP);
                second   = sec_wrap ? 6'd0 : second + 6'd1;
                want.seconds_changed = 1'b1;
                if (sec_wrap) begin
                    min_wrap = (minute >= MINSEC_TOP);
                    minute   = min_wrap ? 6'd0 : minute + 6'd1;
                    want.minutes_changed = 1'b1;
                end
                if (min_wrap) begin
                    hour = (hour >= HOUR_TOP) ? HOUR_FIRST : hour + 4'd1;
                    want.hours_changed = 1'b1;
                end
                want.redraw_all = sec_wrap && min_wrap;
            end else begin
                want.touch_region = key_at(x, y);
                case (want.touch_region)
                    REGION_HOUR_INC: begin
                        hour = (hour >= HOUR_TOP) ? HOUR_FIRST : hour + 4'd1;
                        want.hours_changed = 1'b1;
                    end
                    REGION_MIN_INC: begin
                        minute = (minute >= MINSEC_TOP) ? 6'd0 : minute + 6'd1;
                        want.minutes_changed = 1'b1;
                    end
                    REGION_SEC_INC: begin
                        second = (second >= MINSEC_TOP) ? 6'd0 : second + 6'd1;
                        want.seconds_changed = 1'b1;
                    end
                    REGION_HOUR_DEC: begin
                        hour = (hour <= HOUR_FIRST) ? HOUR_TOP : hour - 4'd1;
                        want.hours_changed = 1'b1;
                    end
                    REGION_MIN_DEC: begin
                        minute = (minute == 6'd0) ? MINSEC_TOP : minute - 6'd1;
                        want.minutes_changed = 1'b1;
                    end
                    REGION_SEC_DEC: begin
                        second = (second == 6'd0) ? MINSEC_TOP : second - 6'd1;
                        want.seconds_changed = 1'b1;
                    end
                    default: ;
                endcase
            end
            h = hour;
            m = minute;
            s = second;
            want.hour_tens   = 1'(h / 10);
            want.hour_ones   = 4'(h % 10);
            want.minute_tens = 3'(m / 10);
            want.minute_ones = 4'(m % 10);
            want.second_tens = 3'(s / 10);
            want.second_ones = 4'(s % 10);
            expected_q.push_back(want);
        endfunction

        function bit field_ok(string name, logic [3:0] want_v, logic [3:0] got_v);
            if (got_v !== want_v)
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name,
                         want_v, got_v);
            return got_v === want_v;
        endfunction

        function void check_result(result_t got);
            result_t want;
            bit      ok;
            if (expected_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            ok = 1'b1;
            ok &= field_ok("hour_tens", 4'(want.hour_tens), 4'(got.hour_tens));
            ok &= field_ok("hour_ones", want.hour_ones, got.hour_ones);
            ok &= field_ok("minute_tens", 4'(want.minute_tens), 4'(got.minute_tens));
            ok &= field_ok("minute_ones", want.minute_ones, got.minute_ones);
            ok &= field_ok("second_tens", 4'(want.second_tens), 4'(got.second_tens));
            ok &= field_ok("second_ones", want.second_ones, got.second_ones);
            ok &= field_ok("hours_changed", 4'(want.hours_changed),
                           4'(got.hours_changed));
            ok &= field_ok("minutes_changed", 4'(want.minutes_changed),
                           4'(got.minutes_changed));
            ok &= field_ok("seconds_changed", 4'(want.seconds_changed),
                           4'(got.seconds_changed));
            ok &= field_ok("redraw_all", 4'(want.redraw_all), 4'(got.redraw_all));
            ok &= field_ok("touch_region", 4'(want.touch_region), 4'(got.touch_region));
            if (!ok) errors++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import thc_pkg::*;
    import clock_tb_pkg::*;

    localparam int COORD_W     = 10;
    localparam int IDLE_PCT    = 37;
    // longest legal quiet stretch is the result hold-off below
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;

    logic clk = 1'b0;
    logic rst_n;

    always #6 clk = ~clk;

    thc_item_if #(.COORD_WIDTH(COORD_W)) item_ch ();
    thc_result_if res_ch ();
    thc_cfg_if #(.COORD_WIDTH(COORD_W), .INDEX_W(CFG_INDEX_W)) cfg_ch ();

    twelve_hour_clock_with_set_keys #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    clock_scoreboard sb = new();

    bit idle_on  = 1'b1;   // random gaps on both sides
    bit hold_req = 1'b0;   // one-shot request for a long result stall
    int quiet_cycles = 0;

    // ------------------------------------------------------------------
    // result side: random back-pressure, changed at the falling edge
    // ------------------------------------------------------------------
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // keep ready low long enough for the result register to fill
                // and the item channel to back up behind it
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                res_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // result beats are checked at the rising edge they are taken
    always @(posedge clk)
    begin : result_mon
        result_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.hour_tens       = res_ch.hour_tens;
            got.hour_ones       = res_ch.hour_ones;
            got.minute_tens     = res_ch.minute_tens;
            got.minute_ones     = res_ch.minute_ones;
            got.second_tens     = res_ch.second_tens;
            got.second_ones     = res_ch.second_ones;
            got.hours_changed   = res_ch.hours_changed;
            got.minutes_changed = res_ch.minutes_changed;
            got.seconds_changed = res_ch.seconds_changed;
            got.redraw_all      = res_ch.redraw_all;
            got.touch_region    = region_t'(res_ch.touch_region);
            sb.check_result(got);
        end
    end

    // watchdog: any beat on any channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("twelve_hour_clock_with_set_keys verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // item side
    // ------------------------------------------------------------------

    // entered and left at a falling edge; valid stays high on return so that
    // back-to-back beats never lower and raise it in one step
    task automatic send_item(logic func, logic [9:0] x, logic [9:0] y);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.func    <= func;
        item_ch.touch_x <= x;
        item_ch.touch_y <= y;
        do @(posedge clk); while (item_ch.ready !== 1'b1);
        sb.note_item(func, x, y);
        @(negedge clk);
    endtask

    // drop valid and wait until every queued beat has come back
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [9:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        sb.set_limit(idx, val);
        @(negedge clk);
    endtask

    // limits only move while the block is idle
    task automatic set_limits(logic [9:0] l, logic [9:0] r, logic [9:0] m);
        settle();
        write_reg(CFG_LEFT_LIMIT, l);
        write_reg(CFG_RIGHT_LIMIT, r);
        write_reg(CFG_ROW_LIMIT, m);
        cfg_ch.valid <= 1'b0;
    endtask

    // a value at or one off a limit, clipped to the screen
    function automatic logic [9:0] near(int lim);
        int v;
        v = lim + int'($urandom_range(2)) - 1;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return v[9:0];
    endfunction

    // any point inside a key; only used when every key has room
    task automatic press(region_t key);
        logic [9:0] x;
        logic [9:0] y;
        case (key)
            REGION_HOUR_INC, REGION_HOUR_DEC:
                x = 10'($urandom_range(sb.left_lim - 1, 0));
            REGION_MIN_INC, REGION_MIN_DEC:
                x = 10'($urandom_range(sb.right_lim - 1, sb.left_lim + 1));
            default:
                x = 10'($urandom_range(1023, sb.right_lim + 1));
        endcase
        if (key == REGION_HOUR_INC || key == REGION_MIN_INC || key == REGION_SEC_INC)
            y = 10'($urandom_range(sb.row_lim - 1, 0));
        else
            y = 10'($urandom_range(1023, sb.row_lim + 1));
        send_item(1'b1, x, y);
    endtask

    // set keys walk the time up to xx:59:59 (sometimes 12:59:59), then ticks
    // roll it over, which is the only way to reach the hour carry quickly
    task automatic rollover_run(output int n);
        n = 0;
        if ($urandom_range(1))
        begin
            while (sb.hour != HOUR_TOP)
            begin
                press(sb.hour >= 4'd6 ? REGION_HOUR_INC : REGION_HOUR_DEC);
                n++;
            end
        end
        while (sb.minute != MINSEC_TOP)
        begin
            press(sb.minute >= 6'd29 ? REGION_MIN_INC : REGION_MIN_DEC);
            n++;
        end
        while (sb.second != MINSEC_TOP)
        begin
            press(sb.second >= 6'd29 ? REGION_SEC_INC : REGION_SEC_DEC);
            n++;
        end
        repeat ($urandom_range(3, 1))
        begin
            send_item(1'b0, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
            n++;
        end
    endtask

    // mix of ticks and touches, touches often landing on or next to a limit
    task automatic random_item();
        logic       func;
        logic [9:0] x;
        logic [9:0] y;
        func = ($urandom_range(99) >= 45);
        x = 10'($urandom_range(1023));
        y = 10'($urandom_range(1023));
        if ($urandom_range(9) < 3) x = near($urandom_range(1) ? sb.left_lim : sb.right_lim);
        if ($urandom_range(9) < 3) y = near(sb.row_lim);
        send_item(func, x, y);
    endtask

    task automatic random_phase(int count);
        int done;
        int n;
        bit roomy;
        roomy = (sb.left_lim >= 1) && (sb.left_lim + 2 <= sb.right_lim)
                && (sb.right_lim <= 1022) && (sb.row_lim >= 1) && (sb.row_lim <= 1022);
        done = 0;
        while (done < count)
        begin
            if (roomy && $urandom_range(99) < 4)
            begin
                rollover_run(n);
                done += n;
            end
            else
            begin
                random_item();
                done++;
            end
        end
    endtask

    // at reset limits: left 106, right 213, row 120
    task automatic directed();
        send_item(1'b0, 10'h3ff, 10'h3ff);  // tick ignores the point: 1:00:01
        send_item(1'b1, 10'd0, 10'd1023);   // hour down wraps 1 -> 12
        send_item(1'b1, 10'd0, 10'd0);      // hour up wraps 12 -> 1
        send_item(1'b1, 10'd0, 10'd1023);   // back to 12
        send_item(1'b1, 10'd150, 10'd1023); // minute down wraps 0 -> 59
        send_item(1'b1, 10'd1023, 10'd1023); // second down 1 -> 0
        send_item(1'b1, 10'd1023, 10'd1023); // second down wraps 0 -> 59
        send_item(1'b0, 10'd0, 10'd0);      // 12:59:59 -> 1:00:00, full redraw
        send_item(1'b1, 10'd150, 10'd1023); // minute 0 -> 59
        send_item(1'b1, 10'd150, 10'd0);    // minute up wraps, no carry to hours
        send_item(1'b1, 10'd1023, 10'd1023); // second 0 -> 59
        send_item(1'b1, 10'd1023, 10'd0);   // second up wraps, no carry to minutes
        send_item(1'b1, 10'd1023, 10'd1023); // second 0 -> 59
        send_item(1'b0, 10'd0, 10'd0);      // tick carries into minutes only
        send_item(1'b1, 10'd106, 10'd0);    // on the left limit: no key
        send_item(1'b1, 10'd213, 10'd1023); // on the right limit: no key
        send_item(1'b1, 10'd50, 10'd120);   // on the row limit: no key
        send_item(1'b1, 10'd106, 10'd120);  // on a corner: no key
        send_item(1'b1, 10'd150, 10'd0);    // minute up
        send_item(1'b1, 10'd1023, 10'd0);   // second up
        send_item(1'b1, 10'd105, 10'd119);  // just inside hour up
        send_item(1'b1, 10'd214, 10'd121);  // just inside second down
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.func    = 1'b0;
        item_ch.touch_x = '0;
        item_ch.touch_y = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_LEFT_LIMIT;
        cfg_ch.data     = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset limits first, untouched by any write
        directed();
        random_phase(230);

        // a stretch with no gaps on either side
        idle_on = 1'b0;
        random_phase(200);
        idle_on = 1'b1;

        // long result stall while items keep coming
        hold_req = 1'b1;
        random_phase(150);

        // extreme limits: only the minute down key is reachable
        set_limits(10'd0, 10'd1023, 10'd0);
        random_phase(150);
        // left above right, row at the top
        set_limits(10'd1023, 10'd0, 10'd1023);
        random_phase(150);
        // all limits equal: many points on a boundary
        set_limits(10'd512, 10'd512, 10'd512);
        random_phase(150);

        repeat (3)
        begin
            set_limits(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                       10'($urandom_range(1023)));
            random_phase(150);
        end

        // wide keys, room for rollover runs
        set_limits(10'd300, 10'd700, 10'd500);
        random_phase(300);

        settle();
        if (sb.errors == 0)
            $display("twelve_hour_clock_with_set_keys verification clean");
        else
            $display("twelve_hour_clock_with_set_keys verification failed");
        $finish;
    end

endmodule
